// ===== sv/sst_pkg.sv =====
// sst_pkg: shared types and constants for the sortable stack unit
// used by sortable_stack_unit and its port checker; no dependencies
`default_nettype none

package sst_pkg;

   // default sizing of the value store
   localparam int STACK_DEPTH_DEF = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   // fixed field widths of the transaction ports
   localparam int OP_W     = 2;
   localparam int PUSH_W   = 32;
   localparam int READ_W   = 32;
   localparam int STATUS_W = 2;
   localparam int DEPTH_W  = 7;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_SORT = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ===== sv/sortable_stack_unit.sv =====
// Push, pop and peek: one transaction per cycle unless a sort runs or the response side
// stalls; a response is registered in the store read stage, then the output register.
// Sort of n stored values (n >= 2): the request side is held off while the bubble passes
// walk the store through its one read and one write port; its response does not wait for
// the passes. Sort of 0 or 1 values costs nothing.
// Reset: synchronous, clears fill count, sort sequencer and handshake state; store kept.
`default_nettype none

// sortable_stack_unit: bounded signed stack in a synchronous memory with a sort sequencer
// depends on sst_pkg
module sortable_stack_unit #(
   parameter int STACK_DEPTH = sst_pkg::STACK_DEPTH_DEF,
   parameter int VALUE_WIDTH = sst_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic        [sst_pkg::OP_W-1:0]     req_operation,
   input  wire logic signed [sst_pkg::PUSH_W-1:0]   req_push_value,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic signed [sst_pkg::READ_W-1:0]   rsp_read_value,
   output      logic        [sst_pkg::STATUS_W-1:0] rsp_status,
   output      logic        [sst_pkg::DEPTH_W-1:0]  rsp_depth_now,
   output      logic                                rsp_is_empty
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_FIRST,
      S_WALK,
      S_TAIL
   } state_type;

   // value store
   logic [VALUE_WIDTH-1:0] store_mem [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   // control state
   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              fill_ff, fill_in;
   logic [ADDR_W-1:0]             idx_ff, idx_in;
   logic [ADDR_W-1:0]             last_ff, last_in;
   logic [VALUE_WIDTH-1:0]        carry_ff, carry_in;

   // read stage
   logic                          p1_valid_ff;
   sst_pkg::status_type           p1_status_ff, p1_status_in;
   logic [sst_pkg::DEPTH_W-1:0]   p1_depth_ff, p1_depth_in;
   logic                          p1_empty_ff, p1_empty_in;
   logic                          p1_use_rd_ff, p1_use_rd_in;

   // output register
   logic                          out_valid_ff;
   logic signed [sst_pkg::READ_W-1:0] out_value_ff;
   sst_pkg::status_type           out_status_ff;
   logic [sst_pkg::DEPTH_W-1:0]   out_depth_ff;
   logic                          out_empty_ff;

   // memory port controls
   logic                          mem_we, mem_re;
   logic [ADDR_W-1:0]             mem_wa, mem_ra;
   logic [VALUE_WIDTH-1:0]        mem_wd;

   logic                          accept, p1_move;
   logic                          is_full, is_zero;
   logic [ADDR_W-1:0]             top_idx;
   sst_pkg::op_type               op;
   logic [VALUE_WIDTH+31:0]       push_ext;
   logic [VALUE_WIDTH+31:0]       read_ext;
   logic [CNT_W+sst_pkg::DEPTH_W-1:0] depth_ext;
   logic                          carry_gt;

   // handshake
   assign p1_move   = p1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = (state_ff == S_IDLE) && (!p1_valid_ff || p1_move);
   assign accept    = req_valid && req_ready;

   // stack pointer views
   assign is_full = (fill_ff == CNT_W'(STACK_DEPTH));
   assign is_zero = (fill_ff == '0);
   assign top_idx = ADDR_W'(fill_ff - CNT_W'(1));
   assign op      = sst_pkg::op_type'(req_operation);

   // width adaption of values in and out of the store
   assign push_ext  = {{VALUE_WIDTH{req_push_value[sst_pkg::PUSH_W-1]}}, req_push_value};
   assign read_ext  = {{32{rd_data_ff[VALUE_WIDTH-1]}}, rd_data_ff};
   assign depth_ext = {{sst_pkg::DEPTH_W{1'b0}}, fill_in};

   // larger value sinks toward the bottom
   assign carry_gt = $signed(carry_ff) > $signed(rd_data_ff);

   // request decode and sort sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      carry_in     = carry_ff;
      p1_status_in = sst_pkg::ST_OK;
      p1_use_rd_in = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wa       = '0;
      mem_ra       = '0;
      mem_wd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (op)
                  sst_pkg::OP_PUSH: begin
                     if (is_full) begin
                        p1_status_in = sst_pkg::ST_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        mem_wa  = ADDR_W'(fill_ff);
                        mem_wd  = push_ext[VALUE_WIDTH-1:0];
                        fill_in = fill_ff + CNT_W'(1);
                     end
                  end
                  sst_pkg::OP_POP: begin
                     if (is_zero) begin
                        p1_status_in = sst_pkg::ST_EMPTY;
                     end else begin
                        mem_re       = 1'b1;
                        mem_ra       = top_idx;
                        fill_in      = fill_ff - CNT_W'(1);
                        p1_use_rd_in = 1'b1;
                     end
                  end
                  sst_pkg::OP_PEEK: begin
                     if (is_zero) begin
                        p1_status_in = sst_pkg::ST_EMPTY;
                     end else begin
                        mem_re       = 1'b1;
                        mem_ra       = top_idx;
                        p1_use_rd_in = 1'b1;
                     end
                  end
                  sst_pkg::OP_SORT: begin
                     if (is_zero) begin
                        p1_status_in = sst_pkg::ST_EMPTY;
                     end else if (fill_ff != CNT_W'(1)) begin
                        state_in = S_LOAD;
                        last_in  = top_idx;
                     end
                  end
                  default: begin
                     p1_status_in = sst_pkg::ST_OK;
                  end
               endcase
            end
         end
         // start of a pass: fetch the bottom entry
         S_LOAD: begin
            mem_re   = 1'b1;
            mem_ra   = '0;
            state_in = S_FIRST;
         end
         // bottom entry becomes the carried value
         S_FIRST: begin
            carry_in = rd_data_ff;
            mem_re   = 1'b1;
            mem_ra   = ADDR_W'(1);
            idx_in   = ADDR_W'(1);
            state_in = S_WALK;
         end
         // keep the smaller value moving up, drop the larger one behind
         S_WALK: begin
            mem_we = 1'b1;
            mem_wa = idx_ff - ADDR_W'(1);
            if (carry_gt) begin
               mem_wd   = carry_ff;
               carry_in = rd_data_ff;
            end else begin
               mem_wd = rd_data_ff;
            end
            if (idx_ff == last_ff) begin
               state_in = S_TAIL;
            end else begin
               mem_re = 1'b1;
               mem_ra = idx_ff + ADDR_W'(1);
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         // smallest of the pass lands at the end of the unsorted range
         S_TAIL: begin
            mem_we = 1'b1;
            mem_wa = last_ff;
            mem_wd = carry_ff;
            if (last_ff == ADDR_W'(1)) begin
               state_in = S_IDLE;
            end else begin
               last_in  = last_ff - ADDR_W'(1);
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      p1_depth_in = depth_ext[sst_pkg::DEPTH_W-1:0];
      p1_empty_in = (fill_in == '0);
   end

   // value store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_ra];
      end
   end

   // control state, read stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         last_ff  <= last_in;
         carry_ff <= carry_in;
         if (accept) begin
            p1_valid_ff  <= 1'b1;
            p1_status_ff <= p1_status_in;
            p1_depth_ff  <= p1_depth_in;
            p1_empty_ff  <= p1_empty_in;
            p1_use_rd_ff <= p1_use_rd_in;
         end else if (p1_move) begin
            p1_valid_ff <= 1'b0;
         end
         if (p1_move) begin
            out_valid_ff  <= 1'b1;
            out_value_ff  <= p1_use_rd_ff ? $signed(read_ext[sst_pkg::READ_W-1:0]) : '0;
            out_status_ff <= p1_status_ff;
            out_depth_ff  <= p1_depth_ff;
            out_empty_ff  <= p1_empty_ff;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_value = out_value_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_depth_now  = out_depth_ff;
   assign rsp_is_empty   = out_empty_ff;

endmodule

`default_nettype wire

// ===== sv/sst_checker.sv =====
// sst_checker: port-level assertions for sortable_stack_unit, bound to the top level
// depends on sst_pkg and sortable_stack_unit
`default_nettype none

module sst_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [sst_pkg::READ_W-1:0]   rsp_read_value,
   input wire logic        [sst_pkg::STATUS_W-1:0] rsp_status,
   input wire logic        [sst_pkg::DEPTH_W-1:0]  rsp_depth_now,
   input wire logic                                rsp_is_empty
);

   // a stalled response transaction is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_depth_now) && $stable(rsp_is_empty))
      else $error("response changed while stalled");

   // empty error leaves nothing stored and returns zero
   a_empty_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sst_pkg::ST_EMPTY |->
         rsp_is_empty && rsp_depth_now == '0 && rsp_read_value == '0)
      else $error("empty error with stored values or data");

   // dropped push implies a non-empty stack and no data
   a_full_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sst_pkg::ST_FULL |-> !rsp_is_empty && rsp_read_value == '0)
      else $error("full error on an empty stack");

   // empty flag agrees with the reported depth
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_depth_now == '0)
      else $error("empty flag with non-zero depth");

endmodule

bind sortable_stack_unit sst_checker u_sst_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_value (rsp_read_value),
   .rsp_status     (rsp_status),
   .rsp_depth_now  (rsp_depth_now),
   .rsp_is_empty   (rsp_is_empty)
);

`default_nettype wire
